@@ src/pcp_pkg.sv @@
// ----------------------------------------------------------------------------
// pcp_pkg: shared constants and types for the point charge potential block
// Field widths, fixed-point formats, status and register codes, FSM states.
// ----------------------------------------------------------------------------
package pcp_pkg;

    localparam int MAX_ATOMS = 1024;
    localparam int GRID_MAX  = 256;
    localparam int ADDR_W    = $clog2(MAX_ATOMS);
    localparam int CNT_W     = $clog2(MAX_ATOMS + 1);

    localparam int COORD_W = 32;              // Q16.16
    localparam int Q_W     = 24;              // Q8.16
    localparam int IDX_W   = 8;
    localparam int POT_W   = 48;              // Q24.24
    localparam int ST_W    = 2;
    localparam int WORD_W  = 3 * COORD_W + Q_W;

    localparam int OFF_W   = IDX_W + 1 + COORD_W;  // idx * step
    localparam int GRID_W  = OFF_W + 1;            // origin + idx * step
    localparam int DIFF_W  = GRID_W + 1;
    localparam int MAG_W   = DIFF_W - 1;
    localparam int HALF_W  = MAG_W / 2;
    localparam int SUM_W   = 2 * MAG_W;            // dx^2 + dy^2 + dz^2
    localparam int QUO_W   = 97;                   // floor(2^96 / S)
    localparam int RAD_W   = QUO_W + 1;            // padded to whole bit pairs
    localparam int INV_W   = RAD_W / 2;            // floor(sqrt(quotient))
    localparam int SREM_W  = INV_W + 3;
    localparam int MUL_W   = 25;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int P_W     = Q_W + INV_W;          // |charge| * inv
    localparam int TERM_SH = 24;
    localparam int TERM_W  = P_W + 1 - TERM_SH;
    localparam int ACC_W   = TERM_W + ADDR_W + 1;
    localparam int CNT7_W  = 7;

    localparam int SH_CROSS = HALF_W + 1;          // 2*hi*lo at bit HALF_W
    localparam int SH_HIGH  = 2 * HALF_W;
    localparam int SH_W     = 6;

    localparam logic signed [ACC_W-1:0] POT_MAX = ACC_W'((64'sd1 <<< (POT_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] POT_MIN = ACC_W'(-(64'sd1 <<< (POT_W - 1)));

    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] CFG_ORG_X  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_ORG_Y  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_ORG_Z  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_STEP_X = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_STEP_Y = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_STEP_Z = 3'd5;
    localparam logic signed [COORD_W-1:0] STEP_RESET = 32'sd65536;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    localparam logic [ST_W-1:0] ST_POT    = 2'd0;
    localparam logic [ST_W-1:0] ST_STORED = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_SAT    = 2'd3;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_GRID = 12'b0000_0000_0010,
        S_READ = 12'b0000_0000_0100,
        S_DIFF = 12'b0000_0000_1000,
        S_SQ   = 12'b0000_0001_0000,
        S_CHK  = 12'b0000_0010_0000,
        S_DIV  = 12'b0000_0100_0000,
        S_SQRT = 12'b0000_1000_0000,
        S_TERM = 12'b0001_0000_0000,
        S_ACC  = 12'b0010_0000_0000,
        S_FIN  = 12'b0100_0000_0000,
        S_DONE = 12'b1000_0000_0000
    } t_state;

    function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] idx);
        if (int'(idx) >= GRID_MAX) begin
            return IDX_W'(GRID_MAX - 1);
        end
        return idx;
    endfunction

endpackage

@@ src/point_charge_potential_on_grid_top.sv @@
// ----------------------------------------------------------------------------
// point_charge_potential_on_grid_top: direct Coulomb summation on a grid
// Stores point charges in an atom table and sums charge / distance at voxels.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser = {new_set, func}; tdata = atom_x, atom_y, atom_z,
//   atom_charge, voxel_i, voxel_j, voxel_k from bit 0 up. A load (func 0)
//   writes one atom into the table; new_set empties the table first.
//   An evaluate (func 1) walks the table and returns the Q24.24 potential.
//   Master stream: tdata = potential, atoms_held; tuser = status. The user
//   makes configuration writes (origin, step) while the block is idle.
// Processing:
//   An evaluate walks the table one stored atom after another; the walk
//   is set by the bit-serial divider and square root applied once per
//   atom, and an atom at zero distance skips both. One item is in work
//   at a time. The block itself does not enforce idle-only config writes.
// Reset and stall:
//   Reset empties the table and restores origin 0 and step 1.0. A finished
//   result waits in the output register while the master is stalled; the
//   next item is accepted meanwhile and its result holds until it drains.
// ----------------------------------------------------------------------------
module point_charge_potential_on_grid_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // atom_x[31:0], atom_y[63:32], atom_z[95:64], atom_charge[119:96],
    // voxel_i[127:120], voxel_j[135:128], voxel_k[143:136]
    input  logic [143:0]                  i_s_tdata,
    // func[0], new_set[1]
    input  logic [1:0]                    i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // potential[47:0], atoms_held[58:48], zero[63:59]
    output logic [63:0]                   o_m_tdata,
    // status[1:0]
    output logic [pcp_pkg::ST_W-1:0]      o_m_tuser,
    input  logic                          i_cfg_we,
    input  logic [pcp_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [pcp_pkg::COORD_W-1:0]   i_cfg_wdata
);

    pcp_pkg::t_state r_state;

    logic signed [pcp_pkg::COORD_W-1:0] r_org_x, r_org_y, r_org_z;
    logic signed [pcp_pkg::COORD_W-1:0] r_step_x, r_step_y, r_step_z;
    logic [pcp_pkg::CNT_W-1:0]          r_total;
    logic [pcp_pkg::CNT_W-1:0]          r_atom;
    logic                               r_out_valid;

    logic [pcp_pkg::WORD_W-1:0]         r_mem [pcp_pkg::MAX_ATOMS];
    logic [pcp_pkg::WORD_W-1:0]         r_rd;

    logic [pcp_pkg::IDX_W-1:0]          r_vi, r_vj, r_vk;
    logic signed [pcp_pkg::GRID_W-1:0]  r_gx, r_gy, r_gz;
    logic [pcp_pkg::MAG_W-1:0]          r_mag_x, r_mag_y, r_mag_z;
    logic [pcp_pkg::Q_W-1:0]            r_qmag;
    logic                               r_qneg;
    logic [1:0]                         r_axis, r_part;
    logic [pcp_pkg::PROD_W-1:0]         r_prod;
    logic [pcp_pkg::SH_W-1:0]           r_psh;
    logic                               r_pv;
    logic [pcp_pkg::SUM_W-1:0]          r_s;
    logic [pcp_pkg::SUM_W-1:0]          r_rem;
    logic [pcp_pkg::QUO_W-1:0]          r_quo;
    logic [pcp_pkg::CNT7_W-1:0]         r_cnt;
    logic [pcp_pkg::RAD_W-1:0]          r_sq;
    logic [pcp_pkg::SREM_W-1:0]         r_srem;
    logic [pcp_pkg::INV_W-1:0]          r_root;
    logic [pcp_pkg::P_W-1:0]            r_p;
    logic signed [pcp_pkg::ACC_W-1:0]   r_acc;
    logic [pcp_pkg::POT_W-1:0]          r_res_pot;
    logic [pcp_pkg::ST_W-1:0]           r_res_st;
    logic [pcp_pkg::POT_W-1:0]          r_out_pot;
    logic [pcp_pkg::ST_W-1:0]           r_out_st;
    logic [pcp_pkg::CNT_W-1:0]          r_out_held;

    logic                               w_accept;
    logic                               w_func;
    logic                               w_new_set;
    logic [pcp_pkg::CNT_W-1:0]          w_slot;
    logic                               w_room;
    logic                               w_mem_we;
    logic                               w_out_free;
    logic                               w_last;
    logic                               w_issue;
    logic [pcp_pkg::MAG_W-1:0]          w_sel;
    logic [pcp_pkg::MUL_W-1:0]          w_ma, w_mb;
    logic [pcp_pkg::SH_W-1:0]           w_sh;
    logic signed [pcp_pkg::OFF_W-1:0]   w_off_x, w_off_y, w_off_z;
    logic signed [pcp_pkg::DIFF_W-1:0]  w_dx, w_dy, w_dz;
    logic [pcp_pkg::SUM_W:0]            w_dsh, w_ddiff;
    logic                               w_dge;
    logic [pcp_pkg::SREM_W-1:0]         w_sx, w_trial;
    logic                               w_sge;
    logic signed [pcp_pkg::P_W:0]       w_sp;
    logic signed [pcp_pkg::TERM_W-1:0]  w_term;

    assign o_s_tready = (r_state == pcp_pkg::S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_func     = i_s_tuser[0];
    assign w_new_set  = i_s_tuser[1];
    assign w_slot     = w_new_set ? '0 : r_total;
    assign w_room     = (w_slot < pcp_pkg::CNT_W'(pcp_pkg::MAX_ATOMS));
    assign w_mem_we   = w_accept && (w_func == pcp_pkg::FUNC_LOAD) && w_room;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_last     = ((r_atom + 1'b1) == r_total);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_held, r_out_pot};
    assign o_m_tuser  = r_out_st;

    // grid point offsets
    assign w_off_x = $signed({1'b0, pcp_pkg::clamp_idx(r_vi)}) * r_step_x;
    assign w_off_y = $signed({1'b0, pcp_pkg::clamp_idx(r_vj)}) * r_step_y;
    assign w_off_z = $signed({1'b0, pcp_pkg::clamp_idx(r_vk)}) * r_step_z;

    assign w_dx = pcp_pkg::DIFF_W'($signed(r_rd[31:0])) - pcp_pkg::DIFF_W'(r_gx);
    assign w_dy = pcp_pkg::DIFF_W'($signed(r_rd[63:32])) - pcp_pkg::DIFF_W'(r_gy);
    assign w_dz = pcp_pkg::DIFF_W'($signed(r_rd[95:64])) - pcp_pkg::DIFF_W'(r_gz);

    // shared multiplier operand select
    always_comb begin
        w_issue = 1'b0;
        w_ma    = '0;
        w_mb    = '0;
        w_sh    = '0;
        case (r_axis)
            2'd0:    w_sel = r_mag_x;
            2'd1:    w_sel = r_mag_y;
            default: w_sel = r_mag_z;
        endcase
        if (r_state == pcp_pkg::S_SQ && r_axis != 2'd3) begin
            w_issue = 1'b1;
            case (r_part)
                2'd0: begin
                    w_ma = pcp_pkg::MUL_W'(w_sel[pcp_pkg::HALF_W-1:0]);
                    w_mb = pcp_pkg::MUL_W'(w_sel[pcp_pkg::HALF_W-1:0]);
                end
                2'd1: begin
                    w_ma = pcp_pkg::MUL_W'(w_sel[pcp_pkg::MAG_W-1:pcp_pkg::HALF_W]);
                    w_mb = pcp_pkg::MUL_W'(w_sel[pcp_pkg::HALF_W-1:0]);
                    w_sh = pcp_pkg::SH_W'(pcp_pkg::SH_CROSS);
                end
                default: begin
                    w_ma = pcp_pkg::MUL_W'(w_sel[pcp_pkg::MAG_W-1:pcp_pkg::HALF_W]);
                    w_mb = pcp_pkg::MUL_W'(w_sel[pcp_pkg::MAG_W-1:pcp_pkg::HALF_W]);
                    w_sh = pcp_pkg::SH_W'(pcp_pkg::SH_HIGH);
                end
            endcase
        end else if (r_state == pcp_pkg::S_TERM && r_part != 2'd2) begin
            w_issue = 1'b1;
            w_ma    = pcp_pkg::MUL_W'(r_qmag);
            if (r_part == 2'd0) begin
                w_mb = r_root[pcp_pkg::MUL_W-1:0];
            end else begin
                w_mb = pcp_pkg::MUL_W'(r_root[pcp_pkg::INV_W-1:pcp_pkg::MUL_W]);
                w_sh = pcp_pkg::SH_W'(pcp_pkg::MUL_W);
            end
        end
    end

    // one quotient bit per cycle
    assign w_dsh   = {r_rem, (r_cnt == pcp_pkg::CNT7_W'(pcp_pkg::QUO_W - 1))};
    assign w_dge   = (w_dsh >= {1'b0, r_s});
    assign w_ddiff = w_dsh - {1'b0, r_s};

    // one root bit per cycle
    assign w_sx    = {r_srem[pcp_pkg::SREM_W-3:0], r_sq[pcp_pkg::RAD_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_sge   = (w_sx >= w_trial);

    // floor of the signed product over 2^24
    assign w_sp   = r_qneg ? -$signed({1'b0, r_p}) : $signed({1'b0, r_p});
    assign w_term = w_sp[pcp_pkg::P_W:pcp_pkg::TERM_SH];

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_slot[pcp_pkg::ADDR_W-1:0]] <= i_s_tdata[pcp_pkg::WORD_W-1:0];
        end
        r_rd <= r_mem[r_atom[pcp_pkg::ADDR_W-1:0]];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcp_pkg::S_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_org_x     <= '0;
            r_org_y     <= '0;
            r_org_z     <= '0;
            r_step_x    <= pcp_pkg::STEP_RESET;
            r_step_y    <= pcp_pkg::STEP_RESET;
            r_step_z    <= pcp_pkg::STEP_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    pcp_pkg::CFG_ORG_X:  r_org_x  <= i_cfg_wdata;
                    pcp_pkg::CFG_ORG_Y:  r_org_y  <= i_cfg_wdata;
                    pcp_pkg::CFG_ORG_Z:  r_org_z  <= i_cfg_wdata;
                    pcp_pkg::CFG_STEP_X: r_step_x <= i_cfg_wdata;
                    pcp_pkg::CFG_STEP_Y: r_step_y <= i_cfg_wdata;
                    pcp_pkg::CFG_STEP_Z: r_step_z <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_state == pcp_pkg::S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                pcp_pkg::S_IDLE: begin
                    if (w_accept) begin
                        if (w_func == pcp_pkg::FUNC_EVAL) begin
                            r_state <= pcp_pkg::S_GRID;
                        end else begin
                            r_total <= w_room ? w_slot + 1'b1 : w_slot;
                            r_state <= pcp_pkg::S_DONE;
                        end
                    end
                end
                pcp_pkg::S_GRID: begin
                    r_state <= (r_total == '0) ? pcp_pkg::S_FIN : pcp_pkg::S_READ;
                end
                pcp_pkg::S_READ: r_state <= pcp_pkg::S_DIFF;
                pcp_pkg::S_DIFF: r_state <= pcp_pkg::S_SQ;
                pcp_pkg::S_SQ: begin
                    if (r_axis == 2'd3) begin
                        r_state <= pcp_pkg::S_CHK;
                    end
                end
                pcp_pkg::S_CHK: begin
                    if (r_s != '0) begin
                        r_state <= pcp_pkg::S_DIV;
                    end else begin
                        r_state <= w_last ? pcp_pkg::S_FIN : pcp_pkg::S_READ;
                    end
                end
                pcp_pkg::S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= pcp_pkg::S_SQRT;
                    end
                end
                pcp_pkg::S_SQRT: begin
                    if (r_cnt == '0) begin
                        r_state <= pcp_pkg::S_TERM;
                    end
                end
                pcp_pkg::S_TERM: begin
                    if (r_part == 2'd2) begin
                        r_state <= pcp_pkg::S_ACC;
                    end
                end
                pcp_pkg::S_ACC: r_state <= w_last ? pcp_pkg::S_FIN : pcp_pkg::S_READ;
                pcp_pkg::S_FIN: r_state <= pcp_pkg::S_DONE;
                pcp_pkg::S_DONE: begin
                    if (w_out_free) begin
                        r_state <= pcp_pkg::S_IDLE;
                    end
                end
                default: r_state <= pcp_pkg::S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        r_psh  <= w_sh;
        r_pv   <= w_issue;
        case (r_state)
            pcp_pkg::S_IDLE: begin
                r_vi <= i_s_tdata[127:120];
                r_vj <= i_s_tdata[135:128];
                r_vk <= i_s_tdata[143:136];
                r_res_pot <= '0;
                r_res_st  <= w_room ? pcp_pkg::ST_STORED : pcp_pkg::ST_FULL;
            end
            pcp_pkg::S_GRID: begin
                r_gx   <= pcp_pkg::GRID_W'(r_org_x) + pcp_pkg::GRID_W'(w_off_x);
                r_gy   <= pcp_pkg::GRID_W'(r_org_y) + pcp_pkg::GRID_W'(w_off_y);
                r_gz   <= pcp_pkg::GRID_W'(r_org_z) + pcp_pkg::GRID_W'(w_off_z);
                r_acc  <= '0;
                r_atom <= '0;
            end
            pcp_pkg::S_DIFF: begin
                r_mag_x <= w_dx[pcp_pkg::DIFF_W-1] ? pcp_pkg::MAG_W'(-w_dx)
                                                   : pcp_pkg::MAG_W'(w_dx);
                r_mag_y <= w_dy[pcp_pkg::DIFF_W-1] ? pcp_pkg::MAG_W'(-w_dy)
                                                   : pcp_pkg::MAG_W'(w_dy);
                r_mag_z <= w_dz[pcp_pkg::DIFF_W-1] ? pcp_pkg::MAG_W'(-w_dz)
                                                   : pcp_pkg::MAG_W'(w_dz);
                r_qneg  <= r_rd[pcp_pkg::WORD_W-1];
                r_qmag  <= r_rd[pcp_pkg::WORD_W-1] ? -r_rd[pcp_pkg::WORD_W-1 -: pcp_pkg::Q_W]
                                                   : r_rd[pcp_pkg::WORD_W-1 -: pcp_pkg::Q_W];
                r_s     <= '0;
                r_axis  <= 2'd0;
                r_part  <= 2'd0;
            end
            pcp_pkg::S_SQ: begin
                if (r_pv) begin
                    r_s <= r_s + (pcp_pkg::SUM_W'(r_prod) << r_psh);
                end
                if (r_axis != 2'd3) begin
                    if (r_part == 2'd2) begin
                        r_part <= 2'd0;
                        r_axis <= r_axis + 2'd1;
                    end else begin
                        r_part <= r_part + 2'd1;
                    end
                end
            end
            pcp_pkg::S_CHK: begin
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= pcp_pkg::CNT7_W'(pcp_pkg::QUO_W - 1);
                if (r_s == '0) begin
                    r_atom <= r_atom + 1'b1;
                end
            end
            pcp_pkg::S_DIV: begin
                r_rem <= w_dge ? w_ddiff[pcp_pkg::SUM_W-1:0] : w_dsh[pcp_pkg::SUM_W-1:0];
                r_quo <= {r_quo[pcp_pkg::QUO_W-2:0], w_dge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_sq   <= {1'b0, r_quo[pcp_pkg::QUO_W-2:0], w_dge};
                    r_srem <= '0;
                    r_root <= '0;
                    r_cnt  <= pcp_pkg::CNT7_W'(pcp_pkg::INV_W - 1);
                end
            end
            pcp_pkg::S_SQRT: begin
                r_srem <= w_sge ? w_sx - w_trial : w_sx;
                r_root <= {r_root[pcp_pkg::INV_W-2:0], w_sge};
                r_sq   <= {r_sq[pcp_pkg::RAD_W-3:0], 2'b00};
                r_cnt  <= r_cnt - 1'b1;
                r_part <= 2'd0;
                r_p    <= '0;
            end
            pcp_pkg::S_TERM: begin
                if (r_pv) begin
                    r_p <= r_p + (pcp_pkg::P_W'(r_prod) << r_psh);
                end
                if (r_part != 2'd2) begin
                    r_part <= r_part + 2'd1;
                end
            end
            pcp_pkg::S_ACC: begin
                r_acc  <= r_acc + pcp_pkg::ACC_W'(w_term);
                r_atom <= r_atom + 1'b1;
            end
            pcp_pkg::S_FIN: begin
                if (r_acc > pcp_pkg::POT_MAX) begin
                    r_res_pot <= pcp_pkg::POT_W'(pcp_pkg::POT_MAX);
                    r_res_st  <= pcp_pkg::ST_SAT;
                end else if (r_acc < pcp_pkg::POT_MIN) begin
                    r_res_pot <= pcp_pkg::POT_W'(pcp_pkg::POT_MIN);
                    r_res_st  <= pcp_pkg::ST_SAT;
                end else begin
                    r_res_pot <= pcp_pkg::POT_W'(r_acc);
                    r_res_st  <= pcp_pkg::ST_POT;
                end
            end
            pcp_pkg::S_DONE: begin
                if (w_out_free) begin
                    r_out_pot  <= r_res_pot;
                    r_out_st   <= r_res_st;
                    r_out_held <= r_total;
                end
            end
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= pcp_pkg::CNT_W'(pcp_pkg::MAX_ATOMS))
        else $error("atom count beyond table depth");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcp_pkg::S_READ) |-> (r_atom < r_total))
        else $error("table walk past last stored atom");

    a_stored_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == pcp_pkg::ST_STORED) |->
        (o_m_tdata[pcp_pkg::POT_W +: pcp_pkg::CNT_W] != '0))
        else $error("stored atom reported with empty table");
`endif

endmodule

@@ tb/point_charge_potential_on_grid_top_tb.sv @@
// ----------------------------------------------------------------------------
// point_charge_potential_on_grid_top_tb: self-checking bench for the grid
// potential block. Streams atom loads and voxel evaluations with random
// stalls on both sides and checks each result against a fixed-point predictor.
// ----------------------------------------------------------------------------
module point_charge_potential_on_grid_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [pcp_pkg::POT_W-1:0] pot;
        logic [pcp_pkg::ST_W-1:0]  status;
        logic [10:0]               held;
    } t_pot_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [143:0] i_s_tdata = '0;
    logic [1:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [63:0]  o_m_tdata;
    logic [pcp_pkg::ST_W-1:0] o_m_tuser;
    logic         i_cfg_we = 1'b0;
    logic [pcp_pkg::CFG_AW-1:0]  i_cfg_addr = '0;
    logic [pcp_pkg::COORD_W-1:0] i_cfg_wdata = '0;

    point_charge_potential_on_grid_top uut (.*);

    always #5 i_clk = ~i_clk;

    // predictor copy of the block state
    longint org [3];
    longint stp [3];
    logic signed [31:0] tab_x [pcp_pkg::MAX_ATOMS];
    logic signed [31:0] tab_y [pcp_pkg::MAX_ATOMS];
    logic signed [31:0] tab_z [pcp_pkg::MAX_ATOMS];
    logic signed [23:0] tab_q [pcp_pkg::MAX_ATOMS];
    int unsigned  atoms_stored;
    t_pot_result  pending_results [$];
    int  errors = 0;
    bit  src_quiet = 1'b0;
    bit  sink_quiet = 1'b0;
    int  sink_hold = 0;

    function automatic longint grid_point(int ax, logic [7:0] idx);
        longint ix;
        ix = (int'(idx) >= pcp_pkg::GRID_MAX) ? pcp_pkg::GRID_MAX - 1 : idx;
        return org[ax] + ix * stp[ax];
    endfunction

    function automatic t_pot_result coulomb_sum(logic [7:0] vi, logic [7:0] vj,
                                                logic [7:0] vk);
        t_pot_result r;
        longint gx, gy, gz, dx, dy, dz;
        logic [127:0] s, quo, n, t, p, term;
        logic signed [127:0] acc;
        gx = grid_point(0, vi);
        gy = grid_point(1, vj);
        gz = grid_point(2, vk);
        acc = '0;
        for (int a = 0; a < atoms_stored; a++) begin
            dx = longint'(tab_x[a]) - gx;
            dy = longint'(tab_y[a]) - gy;
            dz = longint'(tab_z[a]) - gz;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dz < 0) dz = -dz;
            s = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) + 128'(dz) * 128'(dz);
            if (s == 0) continue;
            quo = (128'd1 << 96) / s;
            n = '0;
            for (int b = 48; b >= 0; b--) begin
                t = n | (128'd1 << b);
                if (t * t <= quo) n = t;
            end
            p = 128'(tab_q[a] < 0 ? -longint'(tab_q[a]) : longint'(tab_q[a])) * n;
            term = p >> 24;
            if (tab_q[a] < 0) begin
                if (p[23:0] != 0) term = term + 1;
                acc = acc - $signed(term);
            end else begin
                acc = acc + $signed(term);
            end
        end
        r.status = pcp_pkg::ST_POT;
        if (acc > 128'sd140737488355327) begin
            acc = 128'sd140737488355327;
            r.status = pcp_pkg::ST_SAT;
        end else if (acc < -128'sd140737488355328) begin
            acc = -128'sd140737488355328;
            r.status = pcp_pkg::ST_SAT;
        end
        r.pot = acc[pcp_pkg::POT_W-1:0];
        r.held = atoms_stored[10:0];
        return r;
    endfunction

    function automatic t_pot_result apply_item(logic fn, logic ns, logic [143:0] d);
        t_pot_result r;
        if (fn == pcp_pkg::FUNC_LOAD) begin
            if (ns) atoms_stored = 0;
            r.pot = '0;
            if (atoms_stored < pcp_pkg::MAX_ATOMS) begin
                tab_x[atoms_stored] = d[31:0];
                tab_y[atoms_stored] = d[63:32];
                tab_z[atoms_stored] = d[95:64];
                tab_q[atoms_stored] = d[119:96];
                atoms_stored++;
                r.status = pcp_pkg::ST_STORED;
            end else begin
                r.status = pcp_pkg::ST_FULL;
            end
            r.held = atoms_stored[10:0];
        end else begin
            r = coulomb_sum(d[127:120], d[135:128], d[143:136]);
        end
        return r;
    endfunction

    task automatic send_item(logic fn, logic ns, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [23:0] q, logic [7:0] vi,
                             logic [7:0] vj, logic [7:0] vk);
        t_pot_result predicted;
        while (!src_quiet && $urandom_range(99) < 36) begin
            i_s_tvalid = 1'b0;
            i_s_tdata = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser = {ns, fn};
        i_s_tdata = {vk, vj, vi, q, z, y, x};
        do @(posedge i_clk); while (!o_s_tready);
        predicted = apply_item(fn, ns, i_s_tdata);
        pending_results = {pending_results, predicted};
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic load_atom(logic ns, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [23:0] q);
        send_item(pcp_pkg::FUNC_LOAD, ns, x, y, z, q, 8'($urandom), 8'($urandom),
                  8'($urandom));
    endtask

    task automatic eval_voxel(logic [7:0] vi, logic [7:0] vj, logic [7:0] vk);
        send_item(pcp_pkg::FUNC_EVAL, 1'($urandom), $urandom, $urandom, $urandom,
                  24'($urandom), vi, vj, vk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [pcp_pkg::CFG_AW-1:0] idx, logic [31:0] val);
        i_cfg_we = 1'b1;
        i_cfg_addr = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == pcp_pkg::CFG_ORG_X) org[0] = longint'($signed(val));
        else if (idx == pcp_pkg::CFG_ORG_Y) org[1] = longint'($signed(val));
        else if (idx == pcp_pkg::CFG_ORG_Z) org[2] = longint'($signed(val));
        else if (idx == pcp_pkg::CFG_STEP_X) stp[0] = longint'($signed(val));
        else if (idx == pcp_pkg::CFG_STEP_Y) stp[1] = longint'($signed(val));
        else if (idx == pcp_pkg::CFG_STEP_Z) stp[2] = longint'($signed(val));
    endtask

    task automatic set_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                            logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
        wait_drained();
        write_reg(pcp_pkg::CFG_ORG_X, ox);
        write_reg(pcp_pkg::CFG_ORG_Y, oy);
        write_reg(pcp_pkg::CFG_ORG_Z, oz);
        write_reg(pcp_pkg::CFG_STEP_X, sx);
        write_reg(pcp_pkg::CFG_STEP_Y, sy);
        write_reg(pcp_pkg::CFG_STEP_Z, sz);
    endtask

    // atom coordinate near the default grid, or anywhere now and then
    function automatic logic [31:0] near_coord();
        if ($urandom_range(9) == 0) return $urandom;
        return 32'($signed($urandom_range(32'h0120_0000)) - 32'sh0010_0000);
    endfunction

    function automatic logic [23:0] rand_charge();
        case ($urandom_range(3))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        eval_voxel(8'd0, 8'd0, 8'd0);                     // empty table
        load_atom(1'b1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 24'h01_0000);
        eval_voxel(8'd1, 8'd2, 8'd3);                     // zero distance skipped
        eval_voxel(8'd0, 8'd0, 8'd0);
        eval_voxel(8'hFF, 8'hFF, 8'hFF);
        load_atom(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'h800000);
        eval_voxel(8'hFF, 8'h00, 8'h80);
        load_atom(1'b1, 32'h0000_0001, 32'h0, 32'h0, 24'h7FFFFF);
        eval_voxel(8'd0, 8'd0, 8'd0);                     // largest positive term, just below saturation
        load_atom(1'b1, 32'h0, 32'hFFFF_FFFF, 32'h0, 24'h800000);
        eval_voxel(8'd0, 8'd0, 8'd0);                     // most negative term, exactly at the lower bound
        load_atom(1'b0, 32'h0, 32'h0, 32'h0001_0000, 24'hFFFFFF);
        eval_voxel(8'd0, 8'd0, 8'd0);
        eval_voxel(8'h7F, 8'h01, 8'hFE);
    endtask

    task automatic random_block(int n_sets);
        for (int s = 0; s < n_sets; s++) begin
            int n_atoms = $urandom_range(1, 5);
            if ($urandom_range(9) == 0) begin
                eval_voxel(8'($urandom), 8'($urandom), 8'($urandom));  // stray evaluate
            end
            for (int a = 0; a < n_atoms; a++) begin
                load_atom(a == 0 ? 1'b1 : 1'($urandom_range(9) == 0),
                          near_coord(), near_coord(), near_coord(), rand_charge());
            end
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(3) == 0)
                    eval_voxel(8'($urandom), 8'($urandom), 8'($urandom));
                else
                    eval_voxel(8'($urandom_range(20)), 8'($urandom_range(20)),
                               8'($urandom_range(20)));
            end
        end
    endtask

    task automatic test_grid_settings();
        set_grid(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h0);
        random_block(6);
        set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h0000_0001);
        random_block(6);
        set_grid(32'hFFF8_0000, 32'h0004_0000, 32'h0, 32'h0000_8000, 32'hFFFF_0000,
                 32'h0002_0000);
        wait_drained();
        write_reg(3'(pcp_pkg::CFG_STEP_Z + 1), $urandom);          // unused index
        write_reg(3'(pcp_pkg::CFG_STEP_Z + 2), $urandom);
        random_block(8);
        set_grid(32'h0, 32'h0, 32'h0, pcp_pkg::STEP_RESET, pcp_pkg::STEP_RESET,
                 pcp_pkg::STEP_RESET);
    endtask

    task automatic test_random();
        random_block(37);
        src_quiet = 1'b1;
        sink_quiet = 1'b1;
        random_block(15);
        src_quiet = 1'b0;
        sink_quiet = 1'b0;
        random_block(37);
    endtask

    task automatic test_backpressure();
        wait_drained();
        sink_hold = 300;
        load_atom(1'b1, near_coord(), near_coord(), near_coord(), rand_charge());
        repeat (6) load_atom(1'b0, near_coord(), near_coord(), near_coord(),
                             rand_charge());
        eval_voxel(8'd3, 8'd4, 8'd5);
        wait_drained();
        eval_voxel(8'd9, 8'd1, 8'd0);
    endtask

    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= sink_quiet || ($urandom_range(99) >= 36);
        end
    end

    always @(posedge i_clk) begin
        t_pot_result got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.pot = o_m_tdata[47:0];
            got.held = o_m_tdata[58:48];
            got.status = o_m_tuser;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result pot=%h status=%0d held=%0d",
                         $time, got.pot, got.status, got.held);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.pot !== want.pot) begin
                    $display("%0t: potential expected %h actual %h", $time,
                             want.pot, got.pot);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, got.status);
                    errors++;
                end
                if (got.held !== want.held) begin
                    $display("%0t: atoms_held expected %0d actual %0d", $time,
                             want.held, got.held);
                    errors++;
                end
            end
        end
    end

    initial begin
        #30ms;
        $display("point_charge_potential_on_grid_top_tb NOT OK");
        $finish;
    end

    initial begin
        org = '{0, 0, 0};
        stp = '{65536, 65536, 65536};
        atoms_stored = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_grid_settings();
        test_random();
        test_backpressure();
        wait_drained();
        repeat (200) @(negedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("point_charge_potential_on_grid_top_tb OK");
        end else begin
            $display("point_charge_potential_on_grid_top_tb NOT OK");
        end
        $finish;
    end

endmodule
